>>> sv/fpq_pkg.sv
package fpq_pkg;

  localparam int NUM_VARS_DEF    = 4;
  localparam int MAX_CARD_DEF    = 8;
  localparam int TABLE_DEPTH_DEF = 4096;

  localparam int IDX_W      = 12;
  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int REQ_W      = 2;
  localparam int CARD_W     = 4;
  localparam int MASK_W     = 4;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(VAL_W);

  localparam logic [CARD_W-1:0] CARD_RESET   = 4'd2;
  localparam logic [MASK_W-1:0] FIRST_RESET  = 4'd15;
  localparam logic [MASK_W-1:0] SECOND_RESET = 4'd0;

  localparam logic [REQ_W-1:0] REQ_WR_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE   = 2'd2;

  localparam logic [VAL_W-1:0] VAL_ONES = '1;

  typedef enum logic [2:0] {
    REG_CARD_VAR0,
    REG_CARD_VAR1,
    REG_CARD_VAR2,
    REG_CARD_VAR3,
    REG_FIRST_MEMBERS,
    REG_SECOND_MEMBERS,
    REG_OP_MODE
  } reg_index_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic [VAL_W-1:0] result_value;
    logic             saturated;
    logic             index_out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [MASK_W-1:0][CARD_W-1:0] card_var;
    logic [MASK_W-1:0]             first_members;
    logic [MASK_W-1:0]             second_members;
    logic                          op_mode;
  } cfg_t;

  typedef struct packed {
    logic done;
    logic oor;
  } ag_status_t;

  typedef struct packed {
    logic done;
    logic sat;
  } ar_status_t;

  typedef struct packed {
    logic we_first;
    logic we_second;
    logic rd;
  } tbl_ctrl_t;

  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_ADDR,
    TOP_READ,
    TOP_MATH,
    TOP_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    AG_IDLE,
    AG_PREP,
    AG_CHECK,
    AG_LOAD,
    AG_BITS,
    AG_REDUCE
  } ag_state_t;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MUL,
    AR_MFIN,
    AR_DIV,
    AR_FIN
  } ar_state_t;

endpackage

>>> sv/fpq_cfg_regs.sv
module fpq_cfg_regs import fpq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  reg_index_t reg_sel;
  logic       wr_en;

  assign reg_sel = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MASK_W; i++) begin
        cfg_r.card_var[i] <= CARD_RESET;
      end
      cfg_r.first_members  <= FIRST_RESET;
      cfg_r.second_members <= SECOND_RESET;
      cfg_r.op_mode        <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CARD_VAR0:      cfg_r.card_var[0]    <= pwdata[CARD_W-1:0];
        REG_CARD_VAR1:      cfg_r.card_var[1]    <= pwdata[CARD_W-1:0];
        REG_CARD_VAR2:      cfg_r.card_var[2]    <= pwdata[CARD_W-1:0];
        REG_CARD_VAR3:      cfg_r.card_var[3]    <= pwdata[CARD_W-1:0];
        REG_FIRST_MEMBERS:  cfg_r.first_members  <= pwdata[MASK_W-1:0];
        REG_SECOND_MEMBERS: cfg_r.second_members <= pwdata[MASK_W-1:0];
        REG_OP_MODE:        cfg_r.op_mode        <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_CARD_VAR0:      prdata = CFG_DATA_W'(cfg_r.card_var[0]);
      REG_CARD_VAR1:      prdata = CFG_DATA_W'(cfg_r.card_var[1]);
      REG_CARD_VAR2:      prdata = CFG_DATA_W'(cfg_r.card_var[2]);
      REG_CARD_VAR3:      prdata = CFG_DATA_W'(cfg_r.card_var[3]);
      REG_FIRST_MEMBERS:  prdata = CFG_DATA_W'(cfg_r.first_members);
      REG_SECOND_MEMBERS: prdata = CFG_DATA_W'(cfg_r.second_members);
      REG_OP_MODE:        prdata = CFG_DATA_W'(cfg_r.op_mode);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> sv/fpq_tables.sv
module fpq_tables import fpq_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  tbl_ctrl_t                      ctrl,
  input  logic [$clog2(TABLE_DEPTH)-1:0] addr_f,
  input  logic [$clog2(TABLE_DEPTH)-1:0] addr_s,
  input  logic [VAL_W-1:0]               wdata,
  output logic [VAL_W-1:0]               rdata_f,
  output logic [VAL_W-1:0]               rdata_s
);

  logic [VAL_W-1:0] first_mem  [TABLE_DEPTH];
  logic [VAL_W-1:0] second_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.we_first) begin
      first_mem[addr_f] <= wdata;
    end
    if (ctrl.rd) begin
      rdata_f <= first_mem[addr_f];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.we_second) begin
      second_mem[addr_s] <= wdata;
    end
    if (ctrl.rd) begin
      rdata_s <= second_mem[addr_s];
    end
  end

endmodule

>>> sv/fpq_addr_gen.sv
module fpq_addr_gen import fpq_pkg::*; #(
  parameter int NUM_VARS    = NUM_VARS_DEF,
  parameter int MAX_CARD    = MAX_CARD_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           wr,
  input  logic [IDX_W-1:0]               idx,
  input  cfg_t                           cfg,
  output ag_status_t                     status,
  output logic [$clog2(TABLE_DEPTH)-1:0] addr_f,
  output logic [$clog2(TABLE_DEPTH)-1:0] addr_s
);

  localparam int MSLOTS = (NUM_VARS < MASK_W) ? NUM_VARS : MASK_W;
  localparam int DB     = $clog2(MAX_CARD);
  localparam int CW     = $clog2(MAX_CARD + 1);
  localparam int SZW    = MSLOTS * DB + 1;
  localparam int TW     = SZW + DB - 1;
  localparam int KW     = (IDX_W > MSLOTS * DB) ? IDX_W : MSLOTS * DB;
  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int RW     = ((KW > AW) ? KW : AW) + 1;
  localparam int RSTEPS = (KW >= AW) ? KW - AW + 1 : 1;
  localparam int CMPW   = (TW > IDX_W) ? TW : IDX_W;
  localparam int SCW    = $clog2(MSLOTS + 1);
  localparam int RCW    = $clog2(RSTEPS + 1);

  localparam logic [RW-1:0] RED_INIT  = RW'(TABLE_DEPTH) << (RSTEPS - 1);
  localparam logic [DB-1:0] BMASK_TOP = DB'(1) << (DB - 1);

  function automatic logic [CW-1:0] eff_card(input logic [CARD_W-1:0] c);
    if (c == '0) begin
      return CW'(1);
    end else if (int'(c) > MAX_CARD) begin
      return CW'(MAX_CARD);
    end else begin
      return CW'(c);
    end
  endfunction

  ag_state_t state_r, state_nxt;

  logic [CARD_W-1:0] card_sh_r [MSLOTS];
  logic [MSLOTS-1:0] rm_sh_r, fm_sh_r, sm_sh_r;
  logic [SZW-1:0]    rs_run_r, sf_run_r, ss_run_r;
  logic [SZW-1:0]    rs_arr_r [MSLOTS];
  logic [SZW-1:0]    sf_arr_r [MSLOTS];
  logic [SZW-1:0]    ss_arr_r [MSLOTS];
  logic [MSLOTS-1:0] mem_arr_r;
  logic [TW-1:0]     t_rs_r, t_sf_r, t_ss_r;
  logic              t_mem_r;
  logic [DB-1:0]     bmask_r;
  logic [SCW-1:0]    cnt_r;
  logic [IDX_W-1:0]  rem_r;
  logic [KW-1:0]     kf_r, ks_r;
  logic [RW-1:0]     red_d_r;
  logic [RCW-1:0]    red_cnt_r;
  logic              done_r, oor_r;

  logic [CW-1:0]     cur_c;
  logic              take;
  logic              last_slot;
  logic              last_red;
  logic              out_of_range;
  logic [MASK_W-1:0] res_mask;
  logic [RW-1:0]     kf_w, ks_w;

  assign cur_c        = eff_card(card_sh_r[0]);
  assign take         = t_mem_r && (CMPW'(t_rs_r) <= CMPW'(rem_r));
  assign last_slot    = (cnt_r == SCW'(MSLOTS - 1));
  assign last_red     = (red_cnt_r == RCW'(RSTEPS - 1));
  assign out_of_range = (CMPW'(rem_r) >= CMPW'(rs_run_r));
  assign res_mask     = cfg.op_mode ? cfg.first_members
                                    : (cfg.first_members | cfg.second_members);
  assign kf_w         = RW'(kf_r);
  assign ks_w         = RW'(ks_r);

  assign status.done = done_r;
  assign status.oor  = oor_r;
  assign addr_f      = AW'(kf_r);
  assign addr_s      = AW'(ks_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AG_IDLE;
      done_r  <= 1'b0;
      oor_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= 1'b0;
      if (state_r == AG_CHECK && out_of_range) begin
        done_r <= 1'b1;
        oor_r  <= 1'b1;
      end else if (state_r == AG_REDUCE && last_red) begin
        done_r <= 1'b1;
        oor_r  <= 1'b0;
      end
    end
  end

  // Datapath: strides are built low variable first, digits are taken
  // high variable first by restoring division against the running strides.
  always_ff @(posedge clk) begin
    unique case (state_r)
      AG_IDLE: begin
        if (start) begin
          rem_r     <= idx;
          kf_r      <= KW'(idx);
          ks_r      <= KW'(idx);
          red_d_r   <= RED_INIT;
          red_cnt_r <= '0;
          cnt_r     <= '0;
          rs_run_r  <= SZW'(1);
          sf_run_r  <= SZW'(1);
          ss_run_r  <= SZW'(1);
          rm_sh_r   <= res_mask[MSLOTS-1:0];
          fm_sh_r   <= cfg.first_members[MSLOTS-1:0];
          sm_sh_r   <= cfg.second_members[MSLOTS-1:0];
          for (int i = 0; i < MSLOTS; i++) begin
            card_sh_r[i] <= cfg.card_var[i];
          end
        end
      end
      AG_PREP: begin
        for (int i = 0; i < MSLOTS - 1; i++) begin
          card_sh_r[i] <= card_sh_r[i+1];
          rs_arr_r[i]  <= rs_arr_r[i+1];
          sf_arr_r[i]  <= sf_arr_r[i+1];
          ss_arr_r[i]  <= ss_arr_r[i+1];
        end
        rs_arr_r[MSLOTS-1] <= rs_run_r;
        sf_arr_r[MSLOTS-1] <= fm_sh_r[0] ? sf_run_r : '0;
        ss_arr_r[MSLOTS-1] <= sm_sh_r[0] ? ss_run_r : '0;
        mem_arr_r <= (mem_arr_r >> 1) | (MSLOTS'(rm_sh_r[0]) << (MSLOTS - 1));
        rm_sh_r   <= rm_sh_r >> 1;
        fm_sh_r   <= fm_sh_r >> 1;
        sm_sh_r   <= sm_sh_r >> 1;
        if (rm_sh_r[0]) begin
          rs_run_r <= SZW'(rs_run_r * cur_c);
        end
        if (fm_sh_r[0]) begin
          sf_run_r <= SZW'(sf_run_r * cur_c);
        end
        if (sm_sh_r[0]) begin
          ss_run_r <= SZW'(ss_run_r * cur_c);
        end
        cnt_r <= cnt_r + SCW'(1);
      end
      AG_CHECK: begin
        kf_r  <= '0;
        ks_r  <= '0;
        cnt_r <= '0;
      end
      AG_LOAD: begin
        t_rs_r  <= TW'(rs_arr_r[MSLOTS-1]) << (DB - 1);
        t_sf_r  <= TW'(sf_arr_r[MSLOTS-1]) << (DB - 1);
        t_ss_r  <= TW'(ss_arr_r[MSLOTS-1]) << (DB - 1);
        t_mem_r <= mem_arr_r[MSLOTS-1];
        bmask_r <= BMASK_TOP;
        for (int i = MSLOTS - 1; i > 0; i--) begin
          rs_arr_r[i] <= rs_arr_r[i-1];
          sf_arr_r[i] <= sf_arr_r[i-1];
          ss_arr_r[i] <= ss_arr_r[i-1];
        end
        mem_arr_r <= mem_arr_r << 1;
      end
      AG_BITS: begin
        if (take) begin
          rem_r <= IDX_W'(CMPW'(rem_r) - CMPW'(t_rs_r));
          kf_r  <= kf_r + KW'(t_sf_r);
          ks_r  <= ks_r + KW'(t_ss_r);
        end
        t_rs_r  <= t_rs_r >> 1;
        t_sf_r  <= t_sf_r >> 1;
        t_ss_r  <= t_ss_r >> 1;
        bmask_r <= bmask_r >> 1;
        if (bmask_r[0]) begin
          cnt_r <= cnt_r + SCW'(1);
        end
      end
      AG_REDUCE: begin
        if (kf_w >= red_d_r) begin
          kf_r <= KW'(kf_w - red_d_r);
        end
        if (ks_w >= red_d_r) begin
          ks_r <= KW'(ks_w - red_d_r);
        end
        red_d_r   <= red_d_r >> 1;
        red_cnt_r <= red_cnt_r + RCW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AG_IDLE: begin
        if (start) begin
          state_nxt = wr ? AG_REDUCE : AG_PREP;
        end
      end
      AG_PREP: begin
        if (last_slot) begin
          state_nxt = AG_CHECK;
        end
      end
      AG_CHECK: begin
        state_nxt = out_of_range ? AG_IDLE : AG_LOAD;
      end
      AG_LOAD: begin
        state_nxt = AG_BITS;
      end
      AG_BITS: begin
        if (bmask_r[0]) begin
          state_nxt = last_slot ? AG_REDUCE : AG_LOAD;
        end
      end
      AG_REDUCE: begin
        if (last_red) begin
          state_nxt = AG_IDLE;
        end
      end
      default: state_nxt = AG_IDLE;
    endcase
  end

endmodule

>>> sv/fpq_arith.sv
module fpq_arith import fpq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             quot,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output ar_status_t       status,
  output logic [VAL_W-1:0] value
);

  ar_state_t state_r, state_nxt;

  logic [VAL_W-1:0]   a_r, b_r;
  logic [2*VAL_W-1:0] prod_r;
  logic [VAL_W-1:0]   rem_r, qd_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [VAL_W-1:0]   res_r;
  logic               sat_r;

  logic               div_zero;
  logic               div_ovf;
  logic [VAL_W:0]     trial;
  logic [VAL_W:0]     diff;
  logic               ge;
  logic               last_step;

  // The quotient overflows 32 bits exactly when the integer part of a reaches b.
  assign div_zero  = (b == '0);
  assign div_ovf   = (VAL_W'(a[VAL_W-1:FRAC_W]) >= b);
  assign trial     = {rem_r, qd_r[VAL_W-1]};
  assign diff      = trial - {1'b0, b_r};
  assign ge        = (trial >= {1'b0, b_r});
  assign last_step = (cnt_r == '1);

  assign status.done = (state_r == AR_FIN);
  assign status.sat  = sat_r;
  assign value       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      AR_IDLE: begin
        if (start) begin
          a_r   <= a;
          b_r   <= b;
          cnt_r <= '0;
          sat_r <= 1'b0;
          rem_r <= VAL_W'(a[VAL_W-1:FRAC_W]);
          qd_r  <= a << FRAC_W;
          if (quot && div_zero) begin
            res_r <= (a == '0) ? '0 : VAL_ONES;
            sat_r <= (a != '0);
          end else if (quot && div_ovf) begin
            res_r <= VAL_ONES;
            sat_r <= 1'b1;
          end
        end
      end
      AR_MUL: begin
        prod_r <= a_r * b_r;
      end
      AR_MFIN: begin
        if (prod_r[2*VAL_W-1:VAL_W+FRAC_W] != '0) begin
          res_r <= VAL_ONES;
          sat_r <= 1'b1;
        end else begin
          res_r <= prod_r[VAL_W+FRAC_W-1:FRAC_W];
          sat_r <= 1'b0;
        end
      end
      AR_DIV: begin
        rem_r <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
        qd_r  <= {qd_r[VAL_W-2:0], ge};
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (last_step) begin
          res_r <= {qd_r[VAL_W-2:0], ge};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AR_IDLE: begin
        if (start) begin
          if (!quot) begin
            state_nxt = AR_MUL;
          end else if (div_zero || div_ovf) begin
            state_nxt = AR_FIN;
          end else begin
            state_nxt = AR_DIV;
          end
        end
      end
      AR_MUL:  state_nxt = AR_MFIN;
      AR_MFIN: state_nxt = AR_FIN;
      AR_DIV: begin
        if (last_step) begin
          state_nxt = AR_FIN;
        end
      end
      AR_FIN:  state_nxt = AR_IDLE;
      default: state_nxt = AR_IDLE;
    endcase
  end

endmodule

>>> sv/factor_product_quotient_top.sv
// Channel  Direction  Handshake              Beat contents
// in       input      in_valid / in_stall    in_item_t (req_type, entry_index, entry_value)
// out      output     out_valid / out_stall  out_item_t (index, value, saturated, out of range)
// cfg      APB        psel penable pwrite    registers 0..6 at byte address 4*i, pready tied high
//
// One beat is worked on at a time. A table write runs the address reduction modulo
// TABLE_DEPTH, RSTEPS steps long (1 at the defaults), and then writes the table. A compute
// beat builds the strides over the M variable slots, checks the index against their
// range, takes one digit of DB bits per slot, reduces the address, reads both tables and
// multiplies, or in quotient mode divides with the bit-serial divider; an index out of
// range finishes after the check, without reading the tables.
// Reset restores the registers to their reset values; the tables are not cleared.
// in_stall is high while a beat is being worked on or its result waits for the output
// register; a result that waits in the output register does not hold off the next beat.
module factor_product_quotient_top import fpq_pkg::*; #(
  parameter int NUM_VARS    = NUM_VARS_DEF,
  parameter int MAX_CARD    = MAX_CARD_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(TABLE_DEPTH);

  top_state_t state_r, state_nxt;

  cfg_t             cfg;
  ag_status_t       ag_st;
  ar_status_t       ar_st;
  tbl_ctrl_t        tctl;
  logic [AW-1:0]    addr_f, addr_s;
  logic [VAL_W-1:0] rdata_f, rdata_s;
  logic [VAL_W-1:0] ar_value;

  logic [REQ_W-1:0] req_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;
  out_item_t        pend_r, pend_nxt;
  logic             pend_load;
  out_item_t        out_data_r;
  logic             out_valid_r;
  logic             out_load;
  logic             in_acc;
  logic             ag_start;
  logic             ag_wr;
  logic             ar_start;

  assign pready    = 1'b1;
  assign in_stall  = (state_r != TOP_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fpq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  fpq_addr_gen #(
    .NUM_VARS    (NUM_VARS),
    .MAX_CARD    (MAX_CARD),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_addr (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ag_start),
    .wr     (ag_wr),
    .idx    (in_data.entry_index),
    .cfg    (cfg),
    .status (ag_st),
    .addr_f (addr_f),
    .addr_s (addr_s)
  );

  fpq_tables #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_tables (
    .clk     (clk),
    .ctrl    (tctl),
    .addr_f  (addr_f),
    .addr_s  (addr_s),
    .wdata   (val_r),
    .rdata_f (rdata_f),
    .rdata_s (rdata_s)
  );

  fpq_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ar_start),
    .quot   (cfg.op_mode),
    .a      (rdata_f),
    .b      (rdata_s),
    .status (ar_st),
    .value  (ar_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TOP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data.req_type;
      idx_r <= in_data.entry_index;
      val_r <= in_data.entry_value;
    end
    if (pend_load) begin
      pend_r <= pend_nxt;
    end
    if (out_load) begin
      out_data_r <= pend_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ag_start  = 1'b0;
    ag_wr     = 1'b0;
    ar_start  = 1'b0;
    tctl      = '0;
    pend_load = 1'b0;
    pend_nxt  = '0;
    out_load  = 1'b0;
    pend_nxt.result_index = idx_r;
    unique case (state_r)
      TOP_IDLE: begin
        if (in_acc) begin
          unique case (in_data.req_type)
            REQ_WR_FIRST, REQ_WR_SECOND: begin
              ag_start  = 1'b1;
              ag_wr     = 1'b1;
              state_nxt = TOP_ADDR;
            end
            REQ_COMPUTE: begin
              ag_start  = 1'b1;
              state_nxt = TOP_ADDR;
            end
            default: state_nxt = TOP_IDLE;
          endcase
        end
      end
      TOP_ADDR: begin
        if (ag_st.done) begin
          if (req_r == REQ_WR_FIRST) begin
            tctl.we_first = 1'b1;
            state_nxt     = TOP_IDLE;
          end else if (req_r == REQ_WR_SECOND) begin
            tctl.we_second = 1'b1;
            state_nxt      = TOP_IDLE;
          end else if (ag_st.oor) begin
            pend_load                   = 1'b1;
            pend_nxt.index_out_of_range = 1'b1;
            state_nxt                   = TOP_DONE;
          end else begin
            tctl.rd   = 1'b1;
            state_nxt = TOP_READ;
          end
        end
      end
      TOP_READ: begin
        ar_start  = 1'b1;
        state_nxt = TOP_MATH;
      end
      TOP_MATH: begin
        if (ar_st.done) begin
          pend_load             = 1'b1;
          pend_nxt.result_value = ar_value;
          pend_nxt.saturated    = ar_st.sat;
          state_nxt             = TOP_DONE;
        end
      end
      TOP_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = TOP_IDLE;
        end
      end
      default: state_nxt = TOP_IDLE;
    endcase
  end

  a_ag_done_in_addr: assert property (@(posedge clk) disable iff (!rst_n)
    ag_st.done |-> state_r == TOP_ADDR)
    else $error("index unit finished outside the address phase");

  a_ar_done_in_math: assert property (@(posedge clk) disable iff (!rst_n)
    ar_st.done |-> state_r == TOP_MATH)
    else $error("arithmetic unit finished outside the math phase");

  a_oor_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.index_out_of_range) |->
      (out_data_r.result_value == '0 && !out_data_r.saturated))
    else $error("out of range result carries a value");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.req_type == REQ_WR_FIRST || in_data.req_type == REQ_WR_SECOND ||
                in_data.req_type == REQ_COMPUTE)) |=> state_r == TOP_ADDR)
    else $error("accepted beat did not start address generation");

endmodule
